// ===== rtl/pose_iir_filter_bank_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pose IIR filter bank
// Each macro checks one clocked implication on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef POSE_IIR_FILTER_BANK_TOP_ASSERT_SVH
`define POSE_IIR_FILTER_BANK_TOP_ASSERT_SVH

// Same-cycle implication.
`define PIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pif_pkg.sv =====
// ----------------------------------------------------------------------------
// pif_pkg
// Shared types and constants of the pose IIR filter bank.
// ----------------------------------------------------------------------------
package pif_pkg;

  localparam int NUM_FIELDS = 7;
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 66;   // seven full products without overflow
  localparam int FRAC_DROP  = 28;   // Q20.44 -> Q16.16
  localparam int ADDR_W     = 4;
  localparam int STEP_W     = 3;
  localparam int TDATA_W    = NUM_FIELDS * SAMPLE_W;

  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_DROP - 1);

  // Order of the product terms in a lane, one per step.
  localparam logic [STEP_W-1:0] TERM_B0 = 3'd0;
  localparam logic [STEP_W-1:0] TERM_B1 = 3'd1;
  localparam logic [STEP_W-1:0] TERM_A1 = 3'd2;
  localparam logic [STEP_W-1:0] TERM_B2 = 3'd3;
  localparam logic [STEP_W-1:0] TERM_A2 = 3'd4;
  localparam logic [STEP_W-1:0] TERM_B3 = 3'd5;
  localparam logic [STEP_W-1:0] TERM_A3 = 3'd6;
  localparam logic [STEP_W-1:0] TERM_END = 3'd7;

  typedef enum logic [ADDR_W-1:0] {
    REG_ORDER = 4'd0,
    REG_B0    = 4'd1,
    REG_B1    = 4'd2,
    REG_B2    = 4'd3,
    REG_B3    = 4'd4,
    REG_A1    = 4'd5,
    REG_A2    = 4'd6,
    REG_A3    = 4'd7
  } pif_reg_t;

  typedef enum logic [1:0] {
    ORDER_FIRST  = 2'd0,
    ORDER_SECOND = 2'd1,
    ORDER_THIRD  = 2'd2,
    ORDER_ALT    = 2'd3
  } pif_order_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } pif_state_t;

  // Control broadcast from the sequencer to every lane.
  typedef struct packed {
    logic                     load;      // capture new samples
    logic                     run;       // multiply / accumulate step
    logic [STEP_W-1:0]        step;
    logic                     term_en;   // term belongs to the selected order
    logic signed [COEF_W-1:0] coef;
    logic                     acc_neg;   // product of the previous step is feedback
    logic                     commit;    // result leaves, histories advance
    logic                     shift2;
    logic                     shift3;
    logic                     hist_clr;
    logic                     side;
  } pif_ctl_t;

endpackage

// ===== rtl/pif_lane.sv =====
// ----------------------------------------------------------------------------
// pif_lane
// One filter lane: histories per side, one multiplier, wide accumulator,
// round and saturate.
// ----------------------------------------------------------------------------
module pif_lane #(
  parameter int SIDES = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pif_pkg::pif_ctl_t                 ctl,
  input  logic signed [pif_pkg::SAMPLE_W-1:0] sample,
  output logic signed [pif_pkg::SAMPLE_W-1:0] y
);
  import pif_pkg::*;

  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] xh1 [SIDES];
  logic signed [SAMPLE_W-1:0] xh2 [SIDES];
  logic signed [SAMPLE_W-1:0] xh3 [SIDES];
  logic signed [SAMPLE_W-1:0] yh1 [SIDES];
  logic signed [SAMPLE_W-1:0] yh2 [SIDES];
  logic signed [SAMPLE_W-1:0] yh3 [SIDES];
  logic signed [SAMPLE_W-1:0] opd;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_ext;
  logic [ACC_W-1:0]           rnd;
  logic [ACC_W-FRAC_DROP-1:0] shifted;
  logic                       fits;

  always_comb begin
    case (ctl.step)
      TERM_B0: opd = x;
      TERM_B1: opd = xh1[ctl.side];
      TERM_A1: opd = yh1[ctl.side];
      TERM_B2: opd = xh2[ctl.side];
      TERM_A2: opd = yh2[ctl.side];
      TERM_B3: opd = xh3[ctl.side];
      TERM_A3: opd = yh3[ctl.side];
      default: opd = '0;
    endcase
  end

  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= sample;
    end
    if (ctl.run) begin
      prod <= ctl.term_en ? PROD_W'(ctl.coef * opd) : '0;
      if (ctl.step == TERM_B0) begin
        acc <= '0;
      end else if (ctl.acc_neg) begin
        acc <= acc - prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  // Round half up, drop 28 fraction bits, clamp to 32 bits.
  assign rnd     = acc + ROUND_HALF;
  assign shifted = rnd[ACC_W-1:FRAC_DROP];
  assign fits    = (&shifted[ACC_W-FRAC_DROP-1:SAMPLE_W-1]) ||
                   !(|shifted[ACC_W-FRAC_DROP-1:SAMPLE_W-1]);

  always_comb begin
    if (fits) begin
      y = shifted[SAMPLE_W-1:0];
    end else if (shifted[ACC_W-FRAC_DROP-1]) begin
      y = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.hist_clr) begin
      for (int s = 0; s < SIDES; s++) begin
        xh1[s] <= '0;
        xh2[s] <= '0;
        xh3[s] <= '0;
        yh1[s] <= '0;
        yh2[s] <= '0;
        yh3[s] <= '0;
      end
    end else if (ctl.commit) begin
      if (ctl.shift3) begin
        xh3[ctl.side] <= xh2[ctl.side];
        yh3[ctl.side] <= yh2[ctl.side];
      end
      if (ctl.shift2) begin
        xh2[ctl.side] <= xh1[ctl.side];
        yh2[ctl.side] <= yh1[ctl.side];
      end
      xh1[ctl.side] <= x;
      yh1[ctl.side] <= y;
    end
  end

endmodule

// ===== rtl/pif_out.sv =====
// ----------------------------------------------------------------------------
// pif_out
// Merge stage: gathers the lane results into one output item and holds it
// until the sink takes it.
// ----------------------------------------------------------------------------
module pif_out #(
  parameter int VALUES_PER_SIDE = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                side,
  input  logic signed [pif_pkg::SAMPLE_W-1:0] lane_y [VALUES_PER_SIDE],
  output logic                                free,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pif_pkg::TDATA_W-1:0]         m_axis_tdata,
  output logic [0:0]                          m_axis_tuser
);
  import pif_pkg::*;

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_axis_tuser[0] <= side;
    end
  end

  for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_field
    if (k < VALUES_PER_SIDE) begin : g_used
      always_ff @(posedge clk) begin
        if (push) begin
          m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] <= lane_y[k];
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk) begin
        if (push) begin
          m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/pose_iir_filter_bank_top.sv =====
// Sequencing: an accepted item runs through 8 multiply and accumulate steps, then
//   is rounded, saturated and committed to the output register.
// Pacing: items enter one at a time, set by the per-lane multiplier that runs
//   seven product terms plus one fold step in turn; a stalled sink adds its stall.
//   The next item is taken while the previous result waits in the output register.
// Reset: rst is synchronous, active high; clears histories, sets first order, b0 = 1.0.
// ----------------------------------------------------------------------------
// pose_iir_filter_bank_top
// Direct-form-I IIR of order 1..3 on seven pose values per item, one lane
// per value, histories per side and value, rounded and saturated output.
// ----------------------------------------------------------------------------
module pose_iir_filter_bank_top #(
  parameter int VALUES_PER_SIDE = 7,
  parameter int SIDES           = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [pif_pkg::ADDR_W-1:0]          cfg_addr,
  input  logic [pif_pkg::COEF_W-1:0]          cfg_data,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pif_pkg::TDATA_W-1:0]         s_axis_tdata,  // sample_0 .. sample_6
  input  logic [0:0]                          s_axis_tuser,  // side
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pif_pkg::TDATA_W-1:0]         m_axis_tdata,  // filtered_0 .. filtered_6
  output logic [0:0]                          m_axis_tuser   // out_side
);
  import pif_pkg::*;

  `include "pose_iir_filter_bank_top_assert.svh"

  // Configuration registers
  logic [1:0]               filter_order;
  logic signed [COEF_W-1:0] coef_b [4];
  logic signed [COEF_W-1:0] coef_a [4];
  logic                     hist_clr;

  // Sequencer
  pif_state_t        state, state_next;
  logic [STEP_W-1:0] step;
  logic              side;       // history bank in use
  logic              out_side;   // raw side bit, copied to the result
  logic              in_acc;
  logic              out_free;
  logic              commit;
  logic              taps2, taps3;
  pif_ctl_t          ctl;
  logic signed [SAMPLE_W-1:0] lane_y [VALUES_PER_SIDE];

  assign hist_clr = cfg_we && (cfg_addr == REG_ORDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= ORDER_FIRST;
      coef_b[0]    <= COEF_W'(32'sh1000_0000);  // 1.0 in Q4.28
      coef_b[1]    <= '0;
      coef_b[2]    <= '0;
      coef_b[3]    <= '0;
      coef_a[0]    <= '0;
      coef_a[1]    <= '0;
      coef_a[2]    <= '0;
      coef_a[3]    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORDER: filter_order <= cfg_data[1:0];
        REG_B0:    coef_b[0]    <= cfg_data;
        REG_B1:    coef_b[1]    <= cfg_data;
        REG_B2:    coef_b[2]    <= cfg_data;
        REG_B3:    coef_b[3]    <= cfg_data;
        REG_A1:    coef_a[1]    <= cfg_data;
        REG_A2:    coef_a[2]    <= cfg_data;
        REG_A3:    coef_a[3]    <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Order code three runs as first order.
  assign taps2 = (filter_order == ORDER_SECOND) || (filter_order == ORDER_THIRD);
  assign taps3 = (filter_order == ORDER_THIRD);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == ST_FIN) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == TERM_END) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        step <= '0;
      end else if (state == ST_RUN) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Hold the side of the item in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      side     <= (SIDES > 1) && s_axis_tuser[0];
      out_side <= s_axis_tuser[0];
    end
  end

  // Lane control
  always_comb begin
    ctl          = '0;
    ctl.load     = in_acc;
    ctl.run      = (state == ST_RUN);
    ctl.step     = step;
    ctl.commit   = commit;
    ctl.shift2   = taps2;
    ctl.shift3   = taps3;
    ctl.hist_clr = hist_clr;
    ctl.side     = side;
    case (step)
      TERM_B0: begin ctl.coef = coef_b[0]; ctl.term_en = 1'b1;  end
      TERM_B1: begin ctl.coef = coef_b[1]; ctl.term_en = 1'b1;  end
      TERM_A1: begin ctl.coef = coef_a[1]; ctl.term_en = 1'b1;  end
      TERM_B2: begin ctl.coef = coef_b[2]; ctl.term_en = taps2; end
      TERM_A2: begin ctl.coef = coef_a[2]; ctl.term_en = taps2; end
      TERM_B3: begin ctl.coef = coef_b[3]; ctl.term_en = taps3; end
      TERM_A3: begin ctl.coef = coef_a[3]; ctl.term_en = taps3; end
      default: begin ctl.coef = '0;        ctl.term_en = 1'b0;  end
    endcase
    // The product landing now came from the step before: subtract feedback.
    ctl.acc_neg = (step == TERM_B2) || (step == TERM_B3) || (step == TERM_END);
  end

  for (genvar i = 0; i < VALUES_PER_SIDE; i++) begin : g_lane
    pif_lane #(
      .SIDES (SIDES)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
      .y      (lane_y[i])
    );
  end

  pif_out #(
    .VALUES_PER_SIDE (VALUES_PER_SIDE)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (commit),
    .side          (out_side),
    .lane_y        (lane_y),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  `PIF_ASSERT_NEXT(a_accept_starts_run, in_acc, state == ST_RUN && step == TERM_B0,
    "accepted item did not start the lane sequence")
  `PIF_ASSERT_NEXT(a_commit_shows_result, commit, m_axis_tvalid,
    "committed result not presented at the output")
  `PIF_ASSERT_NEXT(a_blocked_result_held, state == ST_FIN && !out_free, state == ST_FIN,
    "finished result left the lanes while the output was full")
  `PIF_ASSERT_NOW(a_no_accept_while_busy, state != ST_IDLE, !s_axis_tready,
    "input taken while an item is in the lanes")

endmodule
